@@ src/prmd_pkg.sv @@
// Package for the paged ROM memory map decoder.
// Holds target codes, address map constants, config indexes and the shared structs.
// No dependencies.
package prmd_pkg;

    // Default count of sideways banks fitted
    localparam int NUM_BANKS_DEF = 16;

    // Field widths
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int BANK_W   = 4;
    localparam int CNT_W    = 4;
    localparam int OFF_W    = 4;
    localparam int EXTRA_W  = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALL_ROMS_WRITABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BANK_RAM_MASK     = 1'b1;

    // Access kind
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Address map
    localparam logic [ADDR_W-1:0] A_PAGED   = 16'h8000;
    localparam logic [ADDR_W-1:0] A_OS      = 16'hc000;
    localparam logic [ADDR_W-1:0] A_IO      = 16'hfc00;
    localparam logic [ADDR_W-1:0] A_HIGH    = 16'hff00;
    localparam logic [ADDR_W-1:0] A_CRTC    = 16'hfe00;
    localparam logic [ADDR_W-1:0] A_VULA    = 16'hfe20;
    localparam logic [ADDR_W-1:0] A_BANKSEL = 16'hfe30;
    localparam logic [ADDR_W-1:0] A_SYSVIA  = 16'hfe40;
    localparam logic [ADDR_W-1:0] A_USERVIA = 16'hfe60;
    localparam logic [ADDR_W-1:0] A_DISC    = 16'hfe80;
    localparam logic [ADDR_W-1:0] A_ECONET  = 16'hfea0;
    localparam logic [ADDR_W-1:0] A_ADC     = 16'hfec0;
    localparam logic [ADDR_W-1:0] A_TUBE    = 16'hfee0;

    // Byte returned by the econet and tube slots
    localparam logic [DATA_W-1:0] EMPTY_BYTE = 8'hfe;

    // Bank selected after reset
    localparam logic [BANK_W-1:0] BANK_RESET = 4'd15;

    typedef enum logic [3:0] {
        TGT_FLAT     = 4'd0,
        TGT_SIDEWAYS = 4'd1,
        TGT_SYSVIA   = 4'd2,
        TGT_USERVIA  = 4'd3,
        TGT_CRTC     = 4'd4,
        TGT_VULA     = 4'd5,
        TGT_DISC     = 4'd6,
        TGT_ADC      = 4'd7,
        TGT_NONE     = 4'd8,
        TGT_BANKSEL  = 4'd9
    } target_t;

    // Architectural state carried from one transaction to the next
    typedef struct packed {
        logic [BANK_W-1:0] paged_bank;
        logic [CNT_W-1:0]  read_io_count;
        logic [CNT_W-1:0]  write_io_count;
        logic              paged_area_dirty;
        logic              swram_dirty;
    } prmd_state_t;

    // Decoded result of one access
    typedef struct packed {
        target_t            target;
        logic [ADDR_W-1:0]  mem_address;
        logic [BANK_W-1:0]  bank;
        logic [OFF_W-1:0]   dev_offset;
        logic               write_enable;
        logic [DATA_W-1:0]  read_constant;
        logic [EXTRA_W-1:0] extra_cycles;
        logic               sideways_ram_dirty;
    } prmd_result_t;

endpackage

@@ src/prmd_decode.sv @@
// Combinational address decoder for one processor access.
// Produces the decoded result and the next architectural state.
// Depends on prmd_pkg.
module prmd_decode #(
    parameter int NUM_BANKS = prmd_pkg::NUM_BANKS_DEF
) (
    input  logic                           cmd,
    input  logic [prmd_pkg::ADDR_W-1:0]    address,
    input  logic [prmd_pkg::DATA_W-1:0]    write_data,
    input  logic                           all_roms_writable,
    input  logic [NUM_BANKS-1:0]           bank_ram_mask,
    input  prmd_pkg::prmd_state_t          cur,
    output prmd_pkg::prmd_state_t          nxt,
    output prmd_pkg::prmd_result_t         res
);
    import prmd_pkg::*;

    localparam int BANK_IDX_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

    logic                 wr;
    logic                 present;
    logic                 ram;
    logic                 io_space;
    logic [CNT_W-1:0]     cnt_inc;
    logic [BANK_W-1:0]    new_bank;
    target_t              tgt;

    assign wr       = (cmd == CMD_WRITE);
    assign present  = ({1'b0, cur.paged_bank} < (BANK_W+1)'(NUM_BANKS));
    assign ram      = present && bank_ram_mask[cur.paged_bank[BANK_IDX_W-1:0]];
    assign io_space = (address >= A_IO) && (address < A_HIGH);
    assign cnt_inc  = (wr ? cur.write_io_count : cur.read_io_count) + CNT_W'(1);
    assign new_bank = write_data[BANK_W-1:0];

    always_comb
    begin
        nxt = cur;
        tgt = TGT_FLAT;
        res = '0;

        if (address < A_PAGED)
        begin
            res.mem_address  = address;
            res.write_enable = wr;
        end
        else if (address < A_OS)
        begin
            tgt = TGT_SIDEWAYS;
            res.mem_address = address - A_PAGED;
            if (wr && present && (all_roms_writable || ram))
            begin
                res.write_enable     = 1'b1;
                nxt.paged_area_dirty = 1'b1;
                if (ram)
                begin
                    nxt.swram_dirty = 1'b1;
                end
            end
        end
        else if (!wr && !io_space)
        begin
            // ROM read: plain memory, no wait states
            res.mem_address = address;
        end
        else
        begin
            // Every write from 0xc000 up and every I/O read is charged
            if (wr)
            begin
                nxt.write_io_count = cnt_inc;
            end
            else
            begin
                nxt.read_io_count = cnt_inc;
            end
            res.extra_cycles = cnt_inc[CNT_W-1] ? EXTRA_W'(2) : EXTRA_W'(1);

            if (!io_space)
            begin
                // ROM write: flat target, write dropped
                res.mem_address = address;
            end
            else
            begin
                tgt = TGT_NONE;
                priority if (address[15:4] == A_SYSVIA[15:4]
                             || address[15:4] == A_SYSVIA[15:4] + 12'd1)
                begin
                    tgt = TGT_SYSVIA;
                    res.dev_offset = address[3:0];
                end
                else if (address[15:4] == A_USERVIA[15:4]
                         || address[15:4] == A_USERVIA[15:4] + 12'd1)
                begin
                    tgt = TGT_USERVIA;
                    res.dev_offset = address[3:0];
                end
                else if (address[15:3] == A_CRTC[15:3])
                begin
                    tgt = TGT_CRTC;
                    res.dev_offset = {1'b0, address[2:0]};
                end
                else if (address[15:4] == A_VULA[15:4])
                begin
                    tgt = TGT_VULA;
                    res.dev_offset = address[3:0];
                end
                else if (address[15:5] == A_DISC[15:5])
                begin
                    tgt = TGT_DISC;
                    res.dev_offset = {1'b0, address[2:0]};
                end
                else if (address[15:5] == A_ADC[15:5])
                begin
                    tgt = TGT_ADC;
                    res.dev_offset = address[3:0];
                end
                else if (wr && address == A_BANKSEL)
                begin
                    tgt = TGT_BANKSEL;
                    // Reselecting the same bank keeps the dirty mark
                    if (new_bank != cur.paged_bank)
                    begin
                        nxt.paged_bank       = new_bank;
                        nxt.paged_area_dirty = 1'b0;
                    end
                end
                else if (!wr && (address[15:5] == A_ECONET[15:5]
                                 || address[15:5] == A_TUBE[15:5]))
                begin
                    res.read_constant = EMPTY_BYTE;
                end
                else
                begin
                    tgt = TGT_NONE;
                end
                res.write_enable = wr && (tgt != TGT_NONE);
            end
        end

        res.target             = tgt;
        res.bank               = nxt.paged_bank;
        res.sideways_ram_dirty = nxt.swram_dirty;
    end

endmodule

@@ src/paged_rom_memory_map_decoder.sv @@
// An accepted transaction moves from the input register into the result register,
// from which the master side takes it. Throughput: one per cycle unless the master stalls.
// Backpressure on the master side stalls the input register, then the slave side.
// Reset (rst_n low, async): bank 15 paged in, I/O counters and dirty flags cleared,
// all_roms_writable 0, bank_ram_mask all ones, both pipeline stages empty.
// Top level of the paged ROM memory map decoder; depends on prmd_pkg, prmd_decode.
module paged_rom_memory_map_decoder #(
    parameter int NUM_BANKS = prmd_pkg::NUM_BANKS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    // Configuration write port
    input  logic                             cfg_we,
    input  logic [prmd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [prmd_pkg::CFG_DATA_W-1:0]  cfg_data,

    // Access stream in
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [23:0]                      s_axis_tdata,  // [15:0] address, [23:16] write_data
    input  logic                             s_axis_tuser,  // [0] cmd

    // Decoded result stream out
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [15:0] mem_address, [19:16] bank, [23:20] dev_offset, [24] write_enable,
    // [32:25] read_constant, [34:33] extra_cycles, [35] sideways_ram_dirty, [39:36] zero
    output logic [39:0]                      m_axis_tdata,
    output logic [3:0]                       m_axis_tuser   // [3:0] target
);
    import prmd_pkg::*;

    // Configuration registers; only fitted banks keep a mask bit
    logic                  all_roms_writable_reg;
    logic [NUM_BANKS-1:0]  bank_ram_mask_reg;

    // Architectural state
    prmd_state_t           state_reg;
    prmd_state_t           state_next;

    // Input stage
    logic                  in_valid_reg;
    logic                  in_cmd_reg;
    logic [ADDR_W-1:0]     in_addr_reg;
    logic [DATA_W-1:0]     in_data_reg;

    // Result stage
    logic                  out_valid_reg;
    prmd_result_t          out_reg;
    prmd_result_t          res_next;

    logic                  out_free;
    logic                  advance;

    // Result register can take a new transaction when empty or draining this cycle
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_roms_writable_reg <= 1'b0;
            bank_ram_mask_reg     <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ALL_ROMS_WRITABLE: all_roms_writable_reg <= cfg_data[0];
                CFG_BANK_RAM_MASK:     bank_ram_mask_reg     <= cfg_data[NUM_BANKS-1:0];
                default:               all_roms_writable_reg <= all_roms_writable_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_cmd_reg  <= s_axis_tuser;
            in_addr_reg <= s_axis_tdata[15:0];
            in_data_reg <= s_axis_tdata[23:16];
        end
    end

    prmd_decode #(
        .NUM_BANKS (NUM_BANKS)
    ) u_decode (
        .cmd               (in_cmd_reg),
        .address           (in_addr_reg),
        .write_data        (in_data_reg),
        .all_roms_writable (all_roms_writable_reg),
        .bank_ram_mask     (bank_ram_mask_reg),
        .cur               (state_reg),
        .nxt               (state_next),
        .res               (res_next)
    );

    // State commits only when the transaction moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.paged_bank       <= BANK_RESET;
            state_reg.read_io_count    <= '0;
            state_reg.write_io_count   <= '0;
            state_reg.paged_area_dirty <= 1'b0;
            state_reg.swram_dirty      <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.target;
    assign m_axis_tdata  = {4'b0000,
                            out_reg.sideways_ram_dirty,
                            out_reg.extra_cycles,
                            out_reg.read_constant,
                            out_reg.write_enable,
                            out_reg.dev_offset,
                            out_reg.bank,
                            out_reg.mem_address};

`ifndef SYNTH
    // A waiting input transaction is never dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_free |=> in_valid_reg)
        else $error("input stage lost a transaction");

    // Bank select write lands in the bank register
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_cmd_reg == CMD_WRITE && in_addr_reg == A_BANKSEL
        |=> state_reg.paged_bank == $past(in_data_reg[BANK_W-1:0]))
        else $error("bank select write not applied");

    // Sideways RAM dirty flag is sticky
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.swram_dirty |=> state_reg.swram_dirty)
        else $error("swram dirty flag cleared");

    // The extra_cycles field never holds its top code; empty slots never accept writes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.extra_cycles != EXTRA_W'(3)
                          && !(out_reg.target == TGT_NONE && out_reg.write_enable))
        else $error("bad extra cycles or write to empty slot");
`endif

endmodule

@@ test/tb_paged_rom_memory_map_decoder.sv @@
// Self-checking testbench for paged_rom_memory_map_decoder: directed and random
// processor accesses are checked against a cycle-free decode predictor.
// Depends on prmd_pkg and the decoder RTL.
`timescale 1ns / 100ps

module tb_paged_rom_memory_map_decoder;

    import prmd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SEG_ACCESSES = 316;   // random transactions per register setting

    // ------------------------------------------------------------------
    // Decode scoreboard: tracks bank, I/O counters and dirty flags the
    // way the decoder should, and holds the decodes still owed by the DUT.
    // ------------------------------------------------------------------
    class decode_scoreboard;
        prmd_result_t pending_decodes[$];
        logic [BANK_W-1:0] cur_bank;
        logic [CNT_W-1:0]  rd_io_count;
        logic [CNT_W-1:0]  wr_io_count;
        logic              area_dirty;
        logic              ram_dirty;
        logic              all_writable;
        logic [15:0]       ram_mask;
        int unsigned       errors;
        int unsigned       accesses;
        int unsigned       results;
        int unsigned       io_accesses;
        int unsigned       bank_switches;
        int unsigned       sideways_writes;
        int unsigned       settings;

        function new();
            cur_bank     = BANK_RESET;
            rd_io_count  = '0;
            wr_io_count  = '0;
            area_dirty   = 1'b0;
            ram_dirty    = 1'b0;
            all_writable = 1'b0;
            ram_mask     = 16'hffff;
            errors = 0; accesses = 0; results = 0;
            io_accesses = 0; bank_switches = 0; sideways_writes = 0; settings = 0;
        endfunction

        function void set_config(logic all_w, logic [15:0] mask);
            all_writable = all_w;
            ram_mask     = mask;
            settings++;
        endfunction

        function int pending();
            return pending_decodes.size();
        endfunction

        // counter bumps first, then bit 3 picks the larger charge
        function logic [EXTRA_W-1:0] io_charge(inout logic [CNT_W-1:0] cnt);
            cnt = cnt + 1'b1;
            io_accesses++;
            return cnt[3] ? 2'd2 : 2'd1;
        endfunction

        // 0xfc00..0xfeff device decode
        function void decode_io(logic wr, logic [15:0] addr, logic [7:0] data,
                                inout prmd_result_t r);
            logic [15:0] blk16;
            logic [15:0] blk32;
            blk16 = addr & 16'hfff0;
            blk32 = addr & 16'hffe0;
            r.target = TGT_NONE;
            if (blk16 == A_SYSVIA || blk16 == A_SYSVIA + 16'h0010)
            begin
                r.target = TGT_SYSVIA;  r.dev_offset = addr[3:0];
            end
            else if (blk16 == A_USERVIA || blk16 == A_USERVIA + 16'h0010)
            begin
                r.target = TGT_USERVIA; r.dev_offset = addr[3:0];
            end
            else if ((addr & 16'hfff8) == A_CRTC)
            begin
                r.target = TGT_CRTC;    r.dev_offset = {1'b0, addr[2:0]};
            end
            else if (blk16 == A_VULA)
            begin
                r.target = TGT_VULA;    r.dev_offset = addr[3:0];
            end
            else if (blk32 == A_DISC)
            begin
                r.target = TGT_DISC;    r.dev_offset = {1'b0, addr[2:0]};
            end
            else if (blk32 == A_ADC)
            begin
                r.target = TGT_ADC;     r.dev_offset = addr[3:0];
            end
            else if (wr && addr == A_BANKSEL)
            begin
                r.target = TGT_BANKSEL;
                // reselecting the current bank keeps the dirty state
                if (data[3:0] != cur_bank)
                begin
                    cur_bank   = data[3:0];
                    area_dirty = 1'b0;
                    bank_switches++;
                end
            end
            else if (!wr && (blk32 == A_ECONET || blk32 == A_TUBE))
                r.read_constant = EMPTY_BYTE;
            r.write_enable = wr && (r.target != TGT_NONE);
        endfunction

        function prmd_result_t predict_decode(logic cmd, logic [15:0] addr,
                                              logic [7:0] data);
            prmd_result_t r;
            logic wr;
            logic fitted;
            logic is_ram;
            r = '0;
            r.target = TGT_FLAT;
            wr = (cmd == CMD_WRITE);
            if (addr < A_PAGED)
            begin
                r.mem_address  = addr;
                r.write_enable = wr;
            end
            else if (addr < A_OS)
            begin
                r.target      = TGT_SIDEWAYS;
                r.mem_address = addr - A_PAGED;
                if (wr)
                begin
                    fitted = int'(cur_bank) < NUM_BANKS_DEF;
                    is_ram = fitted && ram_mask[cur_bank];
                    if (fitted && (all_writable || is_ram))
                    begin
                        r.write_enable = 1'b1;
                        area_dirty     = 1'b1;
                        if (is_ram)
                            ram_dirty = 1'b1;
                        sideways_writes++;
                    end
                end
            end
            else if (!wr)
            begin
                if (addr < A_IO || addr >= A_HIGH)
                    r.mem_address = addr;
                else
                begin
                    r.extra_cycles = io_charge(rd_io_count);
                    decode_io(1'b0, addr, data, r);
                end
            end
            else
            begin
                // every write from 0xc000 up is charged, ROM writes included
                r.extra_cycles = io_charge(wr_io_count);
                if (addr >= A_IO && addr < A_HIGH)
                    decode_io(1'b1, addr, data, r);
                else
                    r.mem_address = addr;
            end
            r.bank               = cur_bank;
            r.sideways_ram_dirty = ram_dirty;
            return r;
        endfunction

        function void note_access(logic cmd, logic [15:0] addr, logic [7:0] data);
            pending_decodes.push_back(predict_decode(cmd, addr, data));
            accesses++;
        endfunction

        function void compare(string name, logic [15:0] expv, logic [15:0] actv);
            if (actv !== expv)
            begin
                errors++;
                $display("%0t: result %0d %s mismatch: expected %h, actual %h",
                         $time, results, name, expv, actv);
            end
        endfunction

        function void check_decode(logic [39:0] data, logic [3:0] user);
            prmd_result_t want;
            if (pending_decodes.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing outstanding: expected none, actual %h/%h",
                         $time, user, data);
                return;
            end
            want = pending_decodes.pop_front();
            compare("target",             16'(want.target),        16'(user));
            compare("mem_address",        want.mem_address,        data[15:0]);
            compare("bank",               16'(want.bank),          16'(data[19:16]));
            compare("dev_offset",         16'(want.dev_offset),    16'(data[23:20]));
            compare("write_enable",       16'(want.write_enable),  16'(data[24]));
            compare("read_constant",      16'(want.read_constant), 16'(data[32:25]));
            compare("extra_cycles",       16'(want.extra_cycles),  16'(data[34:33]));
            compare("sideways_ram_dirty", 16'(want.sideways_ram_dirty), 16'(data[35]));
            compare("tdata padding",      '0,                      16'(data[39:36]));
            results++;
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_ALL_ROMS_WRITABLE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // [15:0] address, [23:16] write_data
    logic        s_axis_tuser  = 1'b0; // [0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [15:0] mem_address, [19:16] bank, [23:20] dev_offset, [24] write_enable,
    // [32:25] read_constant, [34:33] extra_cycles, [35] sideways_ram_dirty
    logic [39:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;         // [3:0] target

    int unsigned src_idle_pct  = 0;
    int unsigned sink_idle_pct = 0;
    int unsigned cycle_count   = 0;

    decode_scoreboard sb = new();

    paged_rom_memory_map_decoder #(
        .NUM_BANKS (NUM_BANKS_DEF)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: sized well beyond the slowest legal run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d decodes outstanding",
                     cycle_count, sb.pending());
            $display("** paged_rom_memory_map_decoder: FAILED **");
            $finish;
        end
    end

    // Result side: check whatever transaction completed at this edge, then
    // pick tready for the next cycle. Values read here are pre-edge values.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_decode(m_axis_tdata, m_axis_tuser);
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // ------------------------------------------------------------------
    // Access side. Tasks are entered just after a rising edge; a transaction
    // is noted in the scoreboard at the edge where it is accepted. tvalid is
    // left high on return so back-to-back transactions need no extra edge.
    // ------------------------------------------------------------------
    task automatic send_access(logic cmd, logic [15:0] addr, logic [7:0] data);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {data, addr};
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_access(cmd, addr, data);
    endtask

    // Drop tvalid and hold off until every outstanding decode has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Both registers, back to back, on an idle block
    task automatic write_config(logic all_w, logic [15:0] mask);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ALL_ROMS_WRITABLE;
        cfg_data  <= {15'b0, all_w};
        @(posedge clk);
        cfg_index <= CFG_BANK_RAM_MASK;
        cfg_data  <= mask;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_config(all_w, mask);
    endtask

    // Random access, weighted toward the paged window, the I/O page and
    // bank switches so that bank, counter and dirty state move a lot.
    task automatic send_random_access();
        int unsigned pick;
        logic        cmd;
        logic [15:0] addr;
        logic [7:0]  data;
        pick = $urandom_range(0, 99);
        cmd  = 1'($urandom_range(0, 1));
        data = 8'($urandom_range(0, 255));
        if (pick < 15)
            addr = 16'($urandom_range(0, A_PAGED - 1));
        else if (pick < 40)
            addr = 16'($urandom_range(A_PAGED, A_OS - 1));
        else if (pick < 48)
            addr = 16'($urandom_range(A_OS, A_IO - 1));
        else if (pick < 55)
            addr = 16'($urandom_range(A_IO, A_CRTC - 1));
        else if (pick < 83)
            addr = {A_CRTC[15:8], 8'($urandom_range(0, 255))};
        else if (pick < 93)
        begin
            // bank select; now and then reselect the bank already paged in
            cmd  = CMD_WRITE;
            addr = A_BANKSEL;
            if ($urandom_range(0, 3) == 0)
                data[3:0] = sb.cur_bank;
        end
        else
            addr = 16'($urandom_range(A_HIGH, 16'hffff));
        send_access(cmd, addr, data);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    logic        seg_all_w[6];
    logic [15:0] seg_mask[6];

    initial
    begin
        // register settings per random segment, extremes included
        seg_all_w[0] = 1'b0; seg_mask[0] = 16'hffff;
        seg_all_w[1] = 1'b1; seg_mask[1] = 16'h0000;
        seg_all_w[2] = 1'b0; seg_mask[2] = 16'h0000;
        seg_all_w[3] = 1'b1; seg_mask[3] = 16'($urandom_range(0, 16'hffff));
        seg_all_w[4] = 1'b0; seg_mask[4] = 16'($urandom_range(0, 16'hffff));
        seg_all_w[5] = 1'b1; seg_mask[5] = 16'hffff;

        src_idle_pct  = 17;
        sink_idle_pct = 53;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, bank 15 paged in, all banks RAM
        send_access(CMD_READ,  16'h0000,         8'h00); // flat, lowest address
        send_access(CMD_WRITE, A_PAGED - 1,      8'hff); // flat write, top of RAM
        send_access(CMD_READ,  A_PAGED,          8'h00); // sideways read
        send_access(CMD_WRITE, A_OS - 1,         8'h5a); // sideways RAM write, sets dirty
        send_access(CMD_READ,  A_OS,             8'h00); // OS ROM read, no charge
        send_access(CMD_WRITE, A_OS,             8'hff); // ROM write, charged but dropped
        send_access(CMD_READ,  16'hffff,         8'h00); // top page read, no charge
        send_access(CMD_WRITE, 16'hffff,         8'h00); // top page write, charged
        send_access(CMD_READ,  A_IO,             8'h00); // empty slot read
        send_access(CMD_WRITE, A_IO + 1,         8'hff); // empty slot write, ignored
        send_access(CMD_READ,  A_CRTC,           8'h00);
        send_access(CMD_WRITE, A_CRTC + 7,       8'hff);
        send_access(CMD_READ,  A_VULA + 15,      8'h00);
        send_access(CMD_READ,  A_BANKSEL,        8'h00); // bank select read -> none
        send_access(CMD_WRITE, A_BANKSEL,        8'h0f); // same bank again
        send_access(CMD_WRITE, A_BANKSEL,        8'ha3); // upper nibble dropped, bank 3
        send_access(CMD_READ,  A_SYSVIA + 15,    8'h00);
        send_access(CMD_WRITE, A_SYSVIA + 16'h1a, 8'h81);
        send_access(CMD_READ,  A_USERVIA + 16'h1f, 8'h00);
        send_access(CMD_WRITE, A_DISC + 16'h1f,  8'h3c);
        send_access(CMD_READ,  A_ECONET + 5,     8'h00); // econet slot -> 0xfe
        send_access(CMD_WRITE, A_ECONET,         8'h77); // econet write ignored
        send_access(CMD_READ,  A_ADC + 15,       8'h00);
        send_access(CMD_READ,  A_TUBE + 31,      8'h00); // tube slot -> 0xfe
        // ROM bank, writes locked, then unlocked by all_roms_writable
        write_config(1'b0, 16'h0000);
        send_access(CMD_WRITE, A_PAGED + 16'h0123, 8'hc3);
        write_config(1'b1, 16'h0000);
        send_access(CMD_WRITE, A_PAGED + 16'h2000, 8'h96);

        // Random: three idle profiles, two register settings each. Each
        // setting change drains the pipe first, which also gives the
        // stop-until-empty case on the access side.
        for (int phase = 0; phase < 3; phase++)
        begin
            wait_drained();
            unique case (phase)
                0: begin src_idle_pct = 17; sink_idle_pct = 53; end
                1: begin src_idle_pct = 53; sink_idle_pct = 17; end
                default: begin src_idle_pct = 0; sink_idle_pct = 0; end
            endcase
            for (int seg = 0; seg < 2; seg++)
            begin
                write_config(seg_all_w[2*phase + seg], seg_mask[2*phase + seg]);
                for (int i = 0; i < SEG_ACCESSES; i++)
                    send_random_access();
            end
        end

        // Drain, then keep clocking so that a stray extra result would still show up
        wait_drained();
        repeat (6) @(posedge clk);

        $display("Checked %0d of %0d accesses: %0d I/O, %0d bank switches, %0d sideways writes",
                 sb.results, sb.accesses, sb.io_accesses, sb.bank_switches,
                 sb.sideways_writes);
        $display("Register settings applied: %0d, mismatches: %0d", sb.settings, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** paged_rom_memory_map_decoder: PASSED **");
        else
            $display("** paged_rom_memory_map_decoder: FAILED **");
        $finish;
    end

endmodule
